@@ design/wsf_pkg.sv @@
// Shared types and constants for the spectral Wiener filter pipeline.
// No dependencies; used by every module of the block.
package wsf_pkg;

  localparam int unsigned QuoBits = 48;   // quotient bits below the overflow point
  localparam int unsigned DivSteps = QuoBits;

  localparam logic [31:0] EpsReset = 32'd66;
  localparam logic [31:0] ScaleReset = 32'hFFFF_FFFF;

  localparam logic CFG_IDX_EPSILON = 1'b0;
  localparam logic CFG_IDX_SCALE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [63:0]         rem;
    logic [QuoBits-1:0]  low;
    logic [QuoBits-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [63:0] den;
    lane_t       re;
    lane_t       im;
  } div_word_t;

endpackage

@@ design/wsf_front.sv @@
// Front end: complex products, denominator, scale multiply, overflow check.
// Five register stages; depends on wsf_pkg.
module wsf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [31:0]        xr,
  input  logic signed [31:0]        xi,
  input  logic signed [31:0]        hr,
  input  logic signed [31:0]        hi,
  input  logic [31:0]               epsilon,
  input  logic [31:0]               norm_scale,
  output wsf_pkg::div_word_t        word_o
);

  // stage 1: products
  logic               v1_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_hh_r, p_gg_r;
  // stage 2: sign/magnitude and denominator
  logic               v2_r, nr_neg_r, ni_neg_r;
  logic [63:0]        nr_mag_r, ni_mag_r, den2_r;
  // stage 3: split scale products
  logic               v3_r, nr_neg3_r, ni_neg3_r;
  logic [63:0]        den3_r, r_lo_r, r_hi_r, i_lo_r, i_hi_r;
  // stage 4: full scaled numerators
  logic               v4_r, nr_neg4_r, ni_neg4_r;
  logic [63:0]        den4_r;
  logic [95:0]        r_prod_r, i_prod_r;
  // stage 5
  wsf_pkg::div_word_t word_r, word_nxt;

  logic signed [64:0] nr_sum, ni_sum;
  logic [64:0]        nr_abs, ni_abs;

  always_comb begin
    nr_sum = {p_rr_r[63], p_rr_r} + {p_ii_r[63], p_ii_r};
    ni_sum = {p_ir_r[63], p_ir_r} - {p_ri_r[63], p_ri_r};
    nr_abs = nr_sum[64] ? 65'(-nr_sum) : 65'(nr_sum);
    ni_abs = ni_sum[64] ? 65'(-ni_sum) : 65'(ni_sum);
  end

  always_comb begin
    word_nxt          = '0;
    word_nxt.valid    = v4_r;
    word_nxt.den      = den4_r;
    word_nxt.zero     = (den4_r == 64'd0);
    word_nxt.re.neg   = nr_neg4_r;
    word_nxt.re.ovf   = {16'd0, r_prod_r[95:48]} >= den4_r;
    word_nxt.re.rem   = {16'd0, r_prod_r[95:48]};
    word_nxt.re.low   = r_prod_r[47:0];
    word_nxt.im.neg   = ni_neg4_r;
    word_nxt.im.ovf   = {16'd0, i_prod_r[95:48]} >= den4_r;
    word_nxt.im.rem   = {16'd0, i_prod_r[95:48]};
    word_nxt.im.low   = i_prod_r[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      word_r.valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= xr * hr;
      p_ii_r <= xi * hi;
      p_ir_r <= xi * hr;
      p_ri_r <= xr * hi;
      p_hh_r <= hr * hr;
      p_gg_r <= hi * hi;

      nr_neg_r <= nr_sum[64];
      ni_neg_r <= ni_sum[64];
      nr_mag_r <= nr_abs[63:0];
      ni_mag_r <= ni_abs[63:0];
      den2_r   <= 64'(p_hh_r) + 64'(p_gg_r) + {16'd0, epsilon, 16'd0};

      nr_neg3_r <= nr_neg_r;
      ni_neg3_r <= ni_neg_r;
      den3_r    <= den2_r;
      r_lo_r    <= nr_mag_r[31:0] * norm_scale;
      r_hi_r    <= nr_mag_r[63:32] * norm_scale;
      i_lo_r    <= ni_mag_r[31:0] * norm_scale;
      i_hi_r    <= ni_mag_r[63:32] * norm_scale;

      nr_neg4_r <= nr_neg3_r;
      ni_neg4_r <= ni_neg3_r;
      den4_r    <= den3_r;
      r_prod_r  <= {32'd0, r_lo_r} + {r_hi_r, 32'd0};
      i_prod_r  <= {32'd0, i_lo_r} + {i_hi_r, 32'd0};
    end
  end

  assign word_o = word_r;

endmodule

@@ design/wsf_div_step.sv @@
// One restoring-division stage: one quotient bit for each lane.
// Depends on wsf_pkg.
module wsf_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wsf_pkg::div_word_t word_i,
  output wsf_pkg::div_word_t word_o
);

  wsf_pkg::div_word_t word_r, word_nxt;
  logic [64:0] re_sh, im_sh;
  logic        re_ge, im_ge;

  always_comb begin
    re_sh = {word_i.re.rem, word_i.re.low[wsf_pkg::QuoBits-1]};
    im_sh = {word_i.im.rem, word_i.im.low[wsf_pkg::QuoBits-1]};
    re_ge = re_sh >= {1'b0, word_i.den};
    im_ge = im_sh >= {1'b0, word_i.den};
    word_nxt        = word_i;
    word_nxt.re.rem = re_ge ? 64'(re_sh - {1'b0, word_i.den}) : re_sh[63:0];
    word_nxt.im.rem = im_ge ? 64'(im_sh - {1'b0, word_i.den}) : im_sh[63:0];
    word_nxt.re.low = {word_i.re.low[wsf_pkg::QuoBits-2:0], 1'b0};
    word_nxt.im.low = {word_i.im.low[wsf_pkg::QuoBits-2:0], 1'b0};
    word_nxt.re.quo = {word_i.re.quo[wsf_pkg::QuoBits-2:0], re_ge};
    word_nxt.im.quo = {word_i.im.quo[wsf_pkg::QuoBits-2:0], im_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.valid <= 1'b0;
    end else if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;

endmodule

@@ design/wiener_spectral_filter_unit.sv @@
// Top level of the spectral Wiener filter: config registers, pipeline, output stage.
// Depends on wsf_pkg, wsf_front and wsf_div_step.
//
//  channel  | direction | word contents (low bit up)
//  ---------+-----------+-------------------------------------------------
//  in_      | sink      | spec_re, spec_im, psf_re, psf_im (32 bits each)
//  out_     | source    | out_re, out_im (32 each), status (2), zero pad
//  cfg_     | sink      | cfg_index selects epsilon (0) or norm_scale (1)
//
// One bin enters every cycle unless out_ stalls; the pipeline holds five
// front-end stages (products, sums, scale multiply, combine, overflow check),
// 48 division stages at one quotient bit each, and the output register.
// Reset is synchronous, active low; it clears valid bits and loads the
// register defaults. A stall at out_ freezes the whole pipeline in place.
module wiener_spectral_filter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // spec_re, spec_im, psf_re, psf_im
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // out_re, out_im, status, 6 zero bits
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] epsilon_r, scale_r;
  logic        en;
  logic        out_valid_r;
  logic [31:0] out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  logic [1:0]  status_r, status_nxt;

  wsf_pkg::div_word_t chain [wsf_pkg::DivSteps+1];
  wsf_pkg::div_word_t last;

  // Advance everything whenever the output register is free or draining.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r <= wsf_pkg::EpsReset;
      scale_r   <= wsf_pkg::ScaleReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wsf_pkg::CFG_IDX_EPSILON: epsilon_r <= cfg_data;
        wsf_pkg::CFG_IDX_SCALE:   scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  wsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .xr         (in_tdata[31:0]),
    .xi         (in_tdata[63:32]),
    .hr         (in_tdata[95:64]),
    .hi         (in_tdata[127:96]),
    .epsilon    (epsilon_r),
    .norm_scale (scale_r),
    .word_o     (chain[0])
  );

  // One quotient bit per stage for both components.
  for (genvar g = 0; g < wsf_pkg::DivSteps; g++) begin : g_div
    wsf_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .word_i (chain[g]),
      .word_o (chain[g+1])
    );
  end

  assign last = chain[wsf_pkg::DivSteps];

  // Saturate each component, apply sign, pick status.
  logic [31:0] re_mag, im_mag, re_lim, im_lim, re_fin, im_fin;
  logic        re_sat, im_sat;

  always_comb begin
    re_lim = last.re.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    im_lim = last.im.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    re_mag = last.re.quo[wsf_pkg::QuoBits-1:16];
    im_mag = last.im.quo[wsf_pkg::QuoBits-1:16];
    re_sat = last.re.ovf || (re_mag > re_lim);
    im_sat = last.im.ovf || (im_mag > im_lim);
    re_fin = re_sat ? re_lim : re_mag;
    im_fin = im_sat ? im_lim : im_mag;
    if (last.zero) begin
      out_re_nxt = '0;
      out_im_nxt = '0;
      status_nxt = wsf_pkg::ST_ZERO_DEN;
    end else begin
      out_re_nxt = last.re.neg ? 32'(-re_fin) : re_fin;
      out_im_nxt = last.im.neg ? 32'(-im_fin) : im_fin;
      status_nxt = (re_sat || im_sat) ? wsf_pkg::ST_SAT : wsf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= out_re_nxt;
      out_im_r <= out_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, status_r, out_im_r, out_re_r};

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status_r == wsf_pkg::ST_OK || status_r == wsf_pkg::ST_SAT ||
                    status_r == wsf_pkg::ST_ZERO_DEN))
    else $error("illegal status code");

  // A zero denominator yields a zero bin.
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == wsf_pkg::ST_ZERO_DEN) |-> (out_re_r == 0 && out_im_r == 0))
    else $error("zero denominator with nonzero output");

  // A saturated bin holds a limit value in at least one component.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == wsf_pkg::ST_SAT) |->
      (out_re_r == 32'h7FFF_FFFF || out_re_r == 32'h8000_0000 ||
       out_im_r == 32'h7FFF_FFFF || out_im_r == 32'h8000_0000))
    else $error("saturation flagged without limit value");

endmodule
